/* rtl/sbag_pkg.sv */
// Package for the scaled blit address generator.
// Holds widths, register indexes, the pipeline word type and the dimension clamp.
// No dependencies.
package sbag_pkg;

    localparam int REG_W    = 13;
    localparam int OFS_W    = 12;
    localparam int IDX_W    = 24;
    localparam int PROD_W   = OFS_W + REG_W;
    localparam int QUOT_W   = 12;
    localparam int POS_W    = 4;
    localparam logic [REG_W-1:0] MAX_DIM = 13'd4096;

    typedef enum logic [2:0] {
        REG_SOURCE_WIDTH  = 3'd0,
        REG_SOURCE_HEIGHT = 3'd1,
        REG_DEST_WIDTH    = 3'd2,
        REG_DEST_HEIGHT   = 3'd3,
        REG_RECT_LEFT     = 3'd4,
        REG_RECT_TOP      = 3'd5,
        REG_RECT_WIDTH    = 3'd6,
        REG_RECT_HEIGHT   = 3'd7
    } sbag_reg_t;

    typedef struct packed {
        logic [REG_W-1:0] source_width;
        logic [REG_W-1:0] source_height;
        logic [REG_W-1:0] dest_width;
        logic [REG_W-1:0] dest_height;
        logic [REG_W-1:0] rect_left;
        logic [REG_W-1:0] rect_top;
        logic [REG_W-1:0] rect_width;
        logic [REG_W-1:0] rect_height;
    } sbag_cfg_t;

    // One word in flight: clip result, destination coordinates and both
    // partial divisions (running remainder and quotient bits found so far).
    typedef struct packed {
        logic              we;
        logic [OFS_W-1:0]  px;
        logic [OFS_W-1:0]  py;
        logic [PROD_W-1:0] rem_x;
        logic [PROD_W-1:0] rem_y;
        logic [QUOT_W-1:0] quo_x;
        logic [QUOT_W-1:0] quo_y;
    } sbag_word_t;

    function automatic logic [REG_W-1:0] sat_dim(input logic [REG_W-1:0] v);
        sat_dim = (v > MAX_DIM) ? MAX_DIM : v;
    endfunction

endpackage

/* rtl/sbag_front.sv */
// Entry stage: clip test, destination coordinates and scale products.
// Depends on sbag_pkg.
module sbag_front (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  sbag_pkg::sbag_cfg_t      cfg,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic [sbag_pkg::OFS_W-1:0] offset_x,
    input  logic [sbag_pkg::OFS_W-1:0] offset_y,
    output logic                     out_valid,
    input  logic                     out_ready,
    output sbag_pkg::sbag_word_t     out_word
);
    import sbag_pkg::*;

    logic            valid_reg, valid_next;
    sbag_word_t      word_reg, word_next;
    logic [REG_W:0]  px_s, py_s;
    logic            in_rect, in_dest;

    assign in_ready = !valid_reg || out_ready;

    always_comb begin
        px_s = {cfg.rect_left[REG_W-1], cfg.rect_left} + {2'b00, offset_x};
        py_s = {cfg.rect_top[REG_W-1], cfg.rect_top} + {2'b00, offset_y};
        in_rect = (cfg.rect_width != '0) && (cfg.rect_height != '0)
                  && ({1'b0, offset_x} < cfg.rect_width)
                  && ({1'b0, offset_y} < cfg.rect_height);
        in_dest = !px_s[REG_W] && (px_s[REG_W-1:0] < cfg.dest_width)
                  && !py_s[REG_W] && (py_s[REG_W-1:0] < cfg.dest_height);
        word_next.we    = in_rect && in_dest;
        word_next.px    = px_s[OFS_W-1:0];
        word_next.py    = py_s[OFS_W-1:0];
        word_next.rem_x = PROD_W'(offset_x) * PROD_W'(cfg.source_width);
        word_next.rem_y = PROD_W'(offset_y) * PROD_W'(cfg.source_height);
        word_next.quo_x = '0;
        word_next.quo_y = '0;
    end

    always_comb begin
        valid_next = valid_reg;
        if (in_ready) begin
            valid_next = in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            word_reg <= word_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_word  = word_reg;

endmodule

/* rtl/sbag_div_cell.sv */
// One cell of the restoring divider chain: finds one quotient bit per lane.
// Depends on sbag_pkg.
module sbag_div_cell (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic [sbag_pkg::POS_W-1:0] bit_pos,
    input  logic [sbag_pkg::REG_W-1:0] div_x,
    input  logic [sbag_pkg::REG_W-1:0] div_y,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  sbag_pkg::sbag_word_t     in_word,
    output logic                     out_valid,
    input  logic                     out_ready,
    output sbag_pkg::sbag_word_t     out_word
);
    import sbag_pkg::*;

    logic              valid_reg, valid_next;
    sbag_word_t        word_reg, word_next;
    logic [PROD_W-1:0] sub_x, sub_y;
    logic [QUOT_W-1:0] bit_mask;

    assign in_ready = !valid_reg || out_ready;

    always_comb begin
        sub_x    = {{(PROD_W-REG_W){1'b0}}, div_x} << bit_pos;
        sub_y    = {{(PROD_W-REG_W){1'b0}}, div_y} << bit_pos;
        bit_mask = {{(QUOT_W-1){1'b0}}, 1'b1} << bit_pos;
        word_next = in_word;
        if (in_word.rem_x >= sub_x) begin
            word_next.rem_x = in_word.rem_x - sub_x;
            word_next.quo_x = in_word.quo_x | bit_mask;
        end
        if (in_word.rem_y >= sub_y) begin
            word_next.rem_y = in_word.rem_y - sub_y;
            word_next.quo_y = in_word.quo_y | bit_mask;
        end
    end

    always_comb begin
        valid_next = valid_reg;
        if (in_ready) begin
            valid_next = in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            word_reg <= word_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_word  = word_reg;

endmodule

/* rtl/sbag_back.sv */
// Output stage: linear destination and source indexes, result register.
// Depends on sbag_pkg.
module sbag_back (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  sbag_pkg::sbag_cfg_t        cfg,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  sbag_pkg::sbag_word_t       in_word,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic                       m_write_enable,
    output logic [sbag_pkg::IDX_W-1:0] m_dest_index,
    output logic [sbag_pkg::IDX_W-1:0] m_source_index
);
    import sbag_pkg::*;

    logic              valid_reg, valid_next;
    logic              we_reg;
    logic [IDX_W-1:0]  dest_reg, dest_next;
    logic [IDX_W-1:0]  src_reg, src_next;
    logic [PROD_W-1:0] dest_full, src_full;

    assign in_ready = !valid_reg || m_ready;

    always_comb begin
        dest_full = PROD_W'(in_word.py) * PROD_W'(cfg.dest_width)
                    + {{(PROD_W-OFS_W){1'b0}}, in_word.px};
        src_full  = PROD_W'(in_word.quo_y) * PROD_W'(cfg.source_width)
                    + {{(PROD_W-QUOT_W){1'b0}}, in_word.quo_x};
        // drop the indexes of a clipped word
        dest_next = in_word.we ? dest_full[IDX_W-1:0] : '0;
        src_next  = in_word.we ? src_full[IDX_W-1:0]  : '0;
    end

    always_comb begin
        valid_next = valid_reg;
        if (in_ready) begin
            valid_next = in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            we_reg   <= in_word.we;
            dest_reg <= dest_next;
            src_reg  <= src_next;
        end
    end

    assign m_valid        = valid_reg;
    assign m_write_enable = we_reg;
    assign m_dest_index   = dest_reg;
    assign m_source_index = src_reg;

endmodule

/* rtl/scaled_blit_address_generator.sv */
// Nearest-neighbor scaled blit address generator, top level.
// Holds the register file and chains front stage, divider cells and output stage.
// Depends on sbag_pkg, sbag_front, sbag_div_cell, sbag_back.
//
// Usage:
//   Program the eight 13-bit registers through cfg_valid/cfg_ready, cfg_index,
//   cfg_data while no word is in flight; cfg_ready is always high. Width and
//   height values above 4096 are saturated to 4096.
//   Each s_ word carries one offset (x, y) inside the target rectangle; each
//   m_ word returns the write flag, destination index and source index for it,
//   in order. Clipped offsets come back with the flag and both indexes zero.
//   The entry stage registers the accepted word; then one divider cell per
//   quotient bit (12 cells, two lanes each) and the output stage each
//   register it in turn. Throughput is one word per cycle while m_ready
//   is high; every stage has its own valid bit and takes a new word when
//   it is empty or its neighbor takes its word, so the chain keeps filling
//   while a result waits on m_ready. When m_ready stays low the chain fills
//   up and s_ready drops once all stages hold a word.
//   Synchronous reset empties the pipeline and loads the register defaults
//   (source 1x1, destination 640x480, rectangle at 0,0 of size 0x0).
module scaled_blit_address_generator (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [2:0]                   cfg_index,
    input  logic [sbag_pkg::REG_W-1:0]   cfg_data,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [sbag_pkg::OFS_W-1:0]   s_offset_x,
    input  logic [sbag_pkg::OFS_W-1:0]   s_offset_y,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic                         m_write_enable,
    output logic [sbag_pkg::IDX_W-1:0]   m_dest_index,
    output logic [sbag_pkg::IDX_W-1:0]   m_source_index
);
    import sbag_pkg::*;

    sbag_cfg_t  cfg_reg, cfg_next;
    logic       link_valid [QUOT_W+1];
    logic       link_ready [QUOT_W+1];
    sbag_word_t link_word  [QUOT_W+1];

    assign cfg_ready = 1'b1;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            case (sbag_reg_t'(cfg_index))
                REG_SOURCE_WIDTH:  cfg_next.source_width  = sat_dim(cfg_data);
                REG_SOURCE_HEIGHT: cfg_next.source_height = sat_dim(cfg_data);
                REG_DEST_WIDTH:    cfg_next.dest_width    = sat_dim(cfg_data);
                REG_DEST_HEIGHT:   cfg_next.dest_height   = sat_dim(cfg_data);
                REG_RECT_LEFT:     cfg_next.rect_left     = cfg_data;
                REG_RECT_TOP:      cfg_next.rect_top      = cfg_data;
                REG_RECT_WIDTH:    cfg_next.rect_width    = sat_dim(cfg_data);
                REG_RECT_HEIGHT:   cfg_next.rect_height   = sat_dim(cfg_data);
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.source_width  <= 13'd1;
            cfg_reg.source_height <= 13'd1;
            cfg_reg.dest_width    <= 13'd640;
            cfg_reg.dest_height   <= 13'd480;
            cfg_reg.rect_left     <= '0;
            cfg_reg.rect_top      <= '0;
            cfg_reg.rect_width    <= '0;
            cfg_reg.rect_height   <= '0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    sbag_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .offset_x  (s_offset_x),
        .offset_y  (s_offset_y),
        .out_valid (link_valid[0]),
        .out_ready (link_ready[0]),
        .out_word  (link_word[0])
    );

    // cell i resolves quotient bit QUOT_W-1-i, most significant first
    for (genvar i = 0; i < QUOT_W; i++) begin : g_cell
        sbag_div_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .bit_pos   (POS_W'(QUOT_W - 1 - i)),
            .div_x     (cfg_reg.rect_width),
            .div_y     (cfg_reg.rect_height),
            .in_valid  (link_valid[i]),
            .in_ready  (link_ready[i]),
            .in_word   (link_word[i]),
            .out_valid (link_valid[i+1]),
            .out_ready (link_ready[i+1]),
            .out_word  (link_word[i+1])
        );
    end

    sbag_back u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg            (cfg_reg),
        .in_valid       (link_valid[QUOT_W]),
        .in_ready       (link_ready[QUOT_W]),
        .in_word        (link_word[QUOT_W]),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_write_enable (m_write_enable),
        .m_dest_index   (m_dest_index),
        .m_source_index (m_source_index)
    );

endmodule

/* tb/tb.sv */
// Self-checking bench for scaled_blit_address_generator: random and directed offsets.
// An internal predictor tracks the eight registers and computes each output word.
// Depends on sbag_pkg and the RTL top level.
module tb;
    import sbag_pkg::*;

    typedef struct {
        logic             write_enable;
        logic [IDX_W-1:0] dest_index;
        logic [IDX_W-1:0] source_index;
    } pixel_t;

    logic             aclk = 1'b0;
    logic             aresetn = 1'b0;
    logic             cfg_valid = 1'b0;
    logic             cfg_ready;
    logic [2:0]       cfg_index = '0;
    logic [REG_W-1:0] cfg_data = '0;
    logic             s_valid = 1'b0;
    logic             s_ready;
    logic [OFS_W-1:0] s_offset_x = '0;
    logic [OFS_W-1:0] s_offset_y = '0;
    logic             m_valid;
    logic             m_ready = 1'b0;
    logic             m_write_enable;
    logic [IDX_W-1:0] m_dest_index;
    logic [IDX_W-1:0] m_source_index;

    // register image as the block sees it after saturation
    int src_w, src_h, dst_w, dst_h, rect_x0, rect_y0, rect_w, rect_h;

    pixel_t expected_pixels[$];
    int     error_count = 0;
    int     send_idle_pct = 0;
    int     recv_idle_pct = 0;
    logic   hold_req = 1'b0;
    int     hold_left = 0;

    scaled_blit_address_generator i_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_offset_x     (s_offset_x),
        .s_offset_y     (s_offset_y),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_write_enable (m_write_enable),
        .m_dest_index   (m_dest_index),
        .m_source_index (m_source_index)
    );

    always #6 aclk = ~aclk;

    function automatic int dim_of(logic [REG_W-1:0] v);
        return (v > MAX_DIM) ? int'(MAX_DIM) : int'(v);
    endfunction

    function automatic void apply_reg(sbag_reg_t idx, logic [REG_W-1:0] v);
        case (idx)
            REG_SOURCE_WIDTH:  src_w = dim_of(v);
            REG_SOURCE_HEIGHT: src_h = dim_of(v);
            REG_DEST_WIDTH:    dst_w = dim_of(v);
            REG_DEST_HEIGHT:   dst_h = dim_of(v);
            REG_RECT_LEFT:     rect_x0 = int'($signed(v));
            REG_RECT_TOP:      rect_y0 = int'($signed(v));
            REG_RECT_WIDTH:    rect_w = dim_of(v);
            REG_RECT_HEIGHT:   rect_h = dim_of(v);
            default: ;
        endcase
    endfunction

    function automatic longint scale_to_source(longint ofs, longint src_dim, longint rect_dim);
        longint c;
        longint last;
        c = (ofs * src_dim) / rect_dim;
        last = (src_dim > 0) ? src_dim - 1 : 0;
        if (c < 0) c = 0;
        if (c > last) c = last;
        return c;
    endfunction

    function automatic pixel_t predict_pixel(logic [OFS_W-1:0] ox, logic [OFS_W-1:0] oy);
        pixel_t p;
        longint x, y, px, py, sx, sy, di, si;
        p.write_enable = 1'b0;
        p.dest_index = '0;
        p.source_index = '0;
        x = longint'(ox);
        y = longint'(oy);
        if (rect_w == 0 || rect_h == 0) return p;
        if (x >= rect_w || y >= rect_h) return p;
        px = rect_x0 + x;
        py = rect_y0 + y;
        if (px < 0 || px >= dst_w || py < 0 || py >= dst_h) return p;
        sx = scale_to_source(x, src_w, rect_w);
        sy = scale_to_source(y, src_h, rect_h);
        di = py * dst_w + px;
        si = sy * src_w + sx;
        p.write_enable = 1'b1;
        p.dest_index = di[IDX_W-1:0];
        p.source_index = si[IDX_W-1:0];
        return p;
    endfunction

    // Half the picks aim at the visible part of the rectangle, a fifth at the whole rectangle, the rest anywhere.
    function automatic logic [OFS_W-1:0] pick_offset(int origin, int rect_dim, int dst_dim);
        int r, lo, hi;
        r = $urandom_range(9);
        lo = (origin < 0) ? -origin : 0;
        hi = (rect_dim < dst_dim - origin) ? rect_dim : dst_dim - origin;
        hi = hi - 1;
        if (hi > 4095) hi = 4095;
        if (r < 5 && hi >= lo && lo <= 4095) return OFS_W'($urandom_range(hi, lo));
        if (r < 7 && rect_dim > 0)
            return OFS_W'($urandom_range((rect_dim > 4096) ? 4095 : rect_dim - 1, 0));
        return OFS_W'($urandom_range(4095, 0));
    endfunction

    function automatic logic [REG_W-1:0] rand_dim();
        int r;
        r = $urandom_range(19);
        if (r == 0) return '0;
        if (r == 1) return REG_W'($urandom_range(8191, 4097));
        if (r == 2) return MAX_DIM;
        if (r < 10) return REG_W'($urandom_range(64, 1));
        return REG_W'($urandom_range(4096, 1));
    endfunction

    function automatic logic [REG_W-1:0] rand_origin();
        logic [REG_W-1:0] v;
        if ($urandom_range(3) == 0) v = REG_W'($urandom_range(8191, 0));
        else v = REG_W'($urandom_range(160, 0) - 32);
        return v;
    endfunction

    task automatic send_offset(logic [OFS_W-1:0] ox, logic [OFS_W-1:0] oy);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_offset_x <= ox;
        s_offset_y <= oy;
        do @(posedge aclk); while (!s_ready);
        expected_pixels.push_back(predict_pixel(ox, oy));
    endtask

    // Drop valid and drain every word in flight.
    task automatic wait_idle();
        s_valid <= 1'b0;
        while (expected_pixels.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    task automatic write_reg(sbag_reg_t idx, logic [REG_W-1:0] v);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= v;
        do @(posedge aclk); while (!cfg_ready);
        apply_reg(idx, v);
    endtask

    task automatic set_config(logic [REG_W-1:0] sw, logic [REG_W-1:0] sh,
                              logic [REG_W-1:0] dw, logic [REG_W-1:0] dh,
                              logic [REG_W-1:0] left, logic [REG_W-1:0] top,
                              logic [REG_W-1:0] rw, logic [REG_W-1:0] rh);
        wait_idle();
        write_reg(REG_SOURCE_WIDTH, sw);
        write_reg(REG_SOURCE_HEIGHT, sh);
        write_reg(REG_DEST_WIDTH, dw);
        write_reg(REG_DEST_HEIGHT, dh);
        write_reg(REG_RECT_LEFT, left);
        write_reg(REG_RECT_TOP, top);
        write_reg(REG_RECT_WIDTH, rw);
        write_reg(REG_RECT_HEIGHT, rh);
        cfg_valid <= 1'b0;
    endtask

    task automatic random_config();
        set_config(rand_dim(), rand_dim(), rand_dim(), rand_dim(),
                   rand_origin(), rand_origin(), rand_dim(), rand_dim());
    endtask

    task automatic send_random_offset();
        send_offset(pick_offset(rect_x0, rect_w, dst_w), pick_offset(rect_y0, rect_h, dst_h));
    endtask

    // Reset leaves an empty rectangle, so nothing is written.
    task automatic test_reset_state();
        send_offset(12'd0, 12'd0);
        send_offset(12'hFFF, 12'hFFF);
    endtask

    task automatic test_full_scale();
        set_config(13'd4096, 13'd4096, 13'd4096, 13'd4096, 13'd0, 13'd0, 13'd4096, 13'd4096);
        send_offset(12'd0, 12'd0);
        send_offset(12'hFFF, 12'hFFF);
        send_offset(12'hFFF, 12'd0);
        send_offset(12'd0, 12'hFFF);
        send_offset(12'hAAA, 12'h555);
    endtask

    task automatic test_clipping();
        set_config(13'd7, 13'd3, 13'd10, 13'd8, -13'sd5, -13'sd3, 13'd20, 13'd10);
        send_offset(12'd0, 12'd0);
        send_offset(12'd5, 12'd3);
        send_offset(12'd14, 12'd10);
        send_offset(12'd19, 12'd9);
        send_offset(12'd20, 12'd4);
        send_offset(12'd14, 12'd10);
        send_offset(12'd9, 12'd7);
    endtask

    // Values above the largest dimension saturate; origins at both signed ends.
    task automatic test_saturation();
        set_config(13'd8191, 13'd5000, 13'd4097, 13'd8191, 13'd0, 13'd0, 13'd4097, 13'd8191);
        send_offset(12'hFFF, 12'hFFF);
        set_config(13'd8191, 13'd8191, 13'd8191, 13'd8191, 13'h0FFF, 13'h1000, 13'd8191, 13'd8191);
        send_offset(12'd0, 12'hFFF);
        send_offset(12'hFFF, 12'd0);
    endtask

    task automatic test_zero_source();
        set_config(13'd0, 13'd0, 13'd640, 13'd480, 13'd2, 13'd1, 13'd16, 13'd16);
        send_offset(12'd3, 12'd5);
        send_offset(12'd15, 12'd15);
        set_config(13'd3, 13'd3, 13'd0, 13'd0, 13'd0, 13'd0, 13'd16, 13'd16);
        send_offset(12'd1, 12'd1);
        send_offset(12'd0, 12'd0);
    endtask

    // Hold the result side while the sender keeps pushing, so the pipe backs up.
    task automatic test_backpressure();
        random_config();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_req = 1'b1;
        repeat (80) send_random_offset();
    endtask

    task automatic test_random_phase(int items, int s_idle, int r_idle);
        send_idle_pct = s_idle;
        recv_idle_pct = r_idle;
        for (int i = 0; i < items; i++) begin
            if (i % 100 == 0) random_config();
            send_random_offset();
        end
    endtask

    always @(posedge aclk) begin
        if (hold_req) begin
            hold_left = 300;
            hold_req = 1'b0;
        end
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge aclk) begin : check_results
        pixel_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_pixels.size() == 0) begin
                error_count++;
                if (error_count <= 10)
                    $display("mismatch at %0t: unexpected word we=%0b dst=%0d src=%0d",
                             $realtime, m_write_enable, m_dest_index, m_source_index);
            end else begin
                want = expected_pixels.pop_front();
                if (m_write_enable !== want.write_enable || m_dest_index !== want.dest_index ||
                    m_source_index !== want.source_index) begin
                    error_count++;
                    if (error_count <= 10)
                        $display("mismatch at %0t: exp we/dst/src %0b/%0d/%0d, got %0b/%0d/%0d",
                                 $realtime, want.write_enable, want.dest_index,
                                 want.source_index, m_write_enable, m_dest_index,
                                 m_source_index);
                end
            end
        end
    end

    initial begin
        src_w = 1;
        src_h = 1;
        dst_w = 640;
        dst_h = 480;
        rect_x0 = 0;
        rect_y0 = 0;
        rect_w = 0;
        rect_h = 0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_reset_state();
        test_full_scale();
        test_clipping();
        test_saturation();
        test_zero_source();
        test_backpressure();
        test_random_phase(700, 13, 48);
        test_random_phase(700, 48, 13);
        test_random_phase(600, 0, 0);
        wait_idle();
        if (error_count == 0 && expected_pixels.size() == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end

    initial begin
        #2400000;
        $display("tb: errors");
        $finish;
    end

endmodule
